/* hw/rtl/moving_average_frame_stats_core_defines.svh */
// ----------------------------------------------------------------------------
// moving_average_frame_stats_core_defines
// assertion macros shared by the moving-average frame statistics core
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FRAME_STATS_CORE_DEFINES_SVH
`define MOVING_AVERAGE_FRAME_STATS_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, quiet while rst_n is low
`define MAFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, quiet while rst_n is low
`define MAFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mafs_pkg.sv */
// ----------------------------------------------------------------------------
// mafs_pkg
// sizes and reciprocal constants for the moving-average frame statistics core
// ----------------------------------------------------------------------------
`default_nettype none

package mafs_pkg;

  // block dimensions
  localparam int unsigned WINDOW     = 20;
  localparam int unsigned FRAME_LEN  = 150;
  localparam int unsigned WARMUP_LEN = 100;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  // derived state widths
  localparam int unsigned HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TOT_W  = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int unsigned FT_W   = $clog2(FRAME_LEN * SAMPLE_MAX + 1);
  localparam int unsigned PH_W   = $clog2(WARMUP_LEN + FRAME_LEN + 1);

  // phase marks
  localparam int unsigned PH_LAST = WARMUP_LEN + FRAME_LEN - 1;

  // floor(x / WINDOW) as (x * WIN_M) >> WIN_K, exact for x < 2**TOT_W
  localparam int unsigned WIN_K   = TOT_W + $clog2(WINDOW);
  localparam int unsigned WIN_M_W = WIN_K - $clog2(WINDOW) + 1;
  localparam int unsigned WIN_P_W = TOT_W + WIN_M_W;
  localparam logic [WIN_M_W-1:0] WIN_M =
    WIN_M_W'(((64'd1 << WIN_K) + WINDOW - 1) / WINDOW);

  // floor(x / FRAME_LEN) as (x * FT_M) >> FT_K, exact for x < 2**FT_W
  localparam int unsigned FT_K   = FT_W + $clog2(FRAME_LEN);
  localparam int unsigned FT_M_W = FT_K - $clog2(FRAME_LEN) + 1;
  localparam int unsigned FT_P_W = FT_W + FT_M_W;
  localparam logic [FT_M_W-1:0] FT_M =
    FT_M_W'(((64'd1 << FT_K) + FRAME_LEN - 1) / FRAME_LEN);

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

/* hw/rtl/moving_average_frame_stats_core.sv */
// ----------------------------------------------------------------------------
// moving_average_frame_stats_core
// moving-average filter over a sample window with per-frame min, max, mean
// and peak-to-peak reporting
// ----------------------------------------------------------------------------
//  channel   direction  payload                                     handshake
//  in_*      input      sample_mv                                   valid/ready
//  out_*     output     filtered, in_frame, frame_index, frame_end, valid/ready
//                       frame_min, frame_max, frame_mean, frame_span
//
//  one beat per cycle sustained while the output is not stalled; each beat passes
//  registered steps in order: window memory read, window sum, divide by window, frame stats, mean.
//  the window memory is read and rewritten at the same entry in the accept
//  cycle; a per-entry valid flag makes never-written entries read as zero.
//  reset (rst_n low, synchronous) clears the window's written flags, sums and frame counters.
//  a stalled output register holds the whole pipeline; in_ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_frame_stats_core_defines.svh"

module moving_average_frame_stats_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mafs_pkg::SAMPLE_W-1:0] in_sample_mv,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mafs_pkg::SAMPLE_W-1:0]      out_filtered,
  output logic                               out_in_frame,
  output logic [mafs_pkg::INDEX_W-1:0]       out_frame_index,
  output logic                               out_frame_end,
  output logic [mafs_pkg::SAMPLE_W-1:0]      out_frame_min,
  output logic [mafs_pkg::SAMPLE_W-1:0]      out_frame_max,
  output logic [mafs_pkg::SAMPLE_W-1:0]      out_frame_mean,
  output logic [mafs_pkg::SAMPLE_W-1:0]      out_frame_span
);

  // window memory and its per-entry written flags
  mafs_pkg::sample_t               win_mem [mafs_pkg::WINDOW];
  mafs_pkg::sample_t               rd_data_r;
  logic [mafs_pkg::WINDOW-1:0]     wr_seen_r;
  logic                            rd_seen_r;
  logic [mafs_pkg::HEAD_W-1:0]     head_r;
  logic [mafs_pkg::HEAD_W-1:0]     head_nxt;

  // pipeline control
  logic adv;
  logic acc;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // stage 1: sample plus old entry
  mafs_pkg::sample_t               samp1_r;
  mafs_pkg::sample_t               old1;
  logic [mafs_pkg::TOT_W-1:0]      total_r;
  logic [mafs_pkg::TOT_W-1:0]      total_nxt;

  // stage 2: window sum to divide
  logic [mafs_pkg::TOT_W-1:0]      tot2_r;
  logic [mafs_pkg::WIN_P_W-1:0]    win_prod;

  // stage 3: filtered value, frame accumulators
  mafs_pkg::sample_t               filt3_r;
  logic [mafs_pkg::PH_W-1:0]       phase_r;
  logic [mafs_pkg::FT_W-1:0]       ft_r;
  logic [mafs_pkg::FT_W-1:0]       ft_nxt;
  mafs_pkg::sample_t               min_r;
  mafs_pkg::sample_t               min_nxt;
  mafs_pkg::sample_t               max_r;
  mafs_pkg::sample_t               max_nxt;
  logic                            kept3;
  logic                            last3;
  logic [mafs_pkg::INDEX_W-1:0]    idx3;

  // stage 4: statistics ready, mean to divide
  mafs_pkg::sample_t               filt4_r;
  logic                            kept4_r;
  logic                            last4_r;
  logic [mafs_pkg::INDEX_W-1:0]    idx4_r;
  mafs_pkg::sample_t               min4_r;
  mafs_pkg::sample_t               max4_r;
  logic [mafs_pkg::FT_W-1:0]       ft4_r;
  logic [mafs_pkg::FT_P_W-1:0]     ft_prod;

  // output register
  mafs_pkg::sample_t               o_filt_r;
  logic                            o_kept_r;
  logic [mafs_pkg::INDEX_W-1:0]    o_idx_r;
  logic                            o_last_r;
  mafs_pkg::sample_t               o_min_r;
  mafs_pkg::sample_t               o_max_r;
  mafs_pkg::sample_t               o_mean_r;
  mafs_pkg::sample_t               o_span_r;

  // whole pipeline moves when the output register is free or drained
  assign adv      = !out_valid_r || out_ready;
  assign acc      = in_valid && adv;
  assign in_ready = adv;

  // head pointer wrap
  assign head_nxt = (head_r == mafs_pkg::HEAD_W'(mafs_pkg::WINDOW - 1)) ?
                    '0 : head_r + 1'b1;

  // window memory: read old entry and overwrite it in the accept cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r       <= win_mem[head_r];
      win_mem[head_r] <= in_sample_mv;
    end
  end

  // running window sum
  assign old1      = rd_seen_r ? rd_data_r : '0;
  assign total_nxt = total_r - mafs_pkg::TOT_W'(old1) + mafs_pkg::TOT_W'(samp1_r);

  // divide window sum by the window length
  assign win_prod = mafs_pkg::WIN_P_W'(tot2_r) * mafs_pkg::WIN_P_W'(mafs_pkg::WIN_M);

  // frame phase decode and accumulator update
  assign kept3   = (phase_r >= mafs_pkg::PH_W'(mafs_pkg::WARMUP_LEN));
  assign last3   = (phase_r == mafs_pkg::PH_W'(mafs_pkg::PH_LAST));
  assign idx3    = kept3 ? mafs_pkg::INDEX_W'(phase_r - mafs_pkg::PH_W'(mafs_pkg::WARMUP_LEN))
                         : '0;
  assign ft_nxt  = ft_r + mafs_pkg::FT_W'(filt3_r);
  assign min_nxt = (filt3_r < min_r) ? filt3_r : min_r;
  assign max_nxt = (filt3_r > max_r) ? filt3_r : max_r;

  // divide frame sum by the frame length
  assign ft_prod = mafs_pkg::FT_P_W'(ft4_r) * mafs_pkg::FT_P_W'(mafs_pkg::FT_M);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      wr_seen_r   <= '0;
      rd_seen_r   <= 1'b0;
      total_r     <= '0;
      phase_r     <= '0;
      ft_r        <= '0;
      min_r       <= '1;
      max_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
      if (in_valid) begin
        rd_seen_r         <= wr_seen_r[head_r];
        wr_seen_r[head_r] <= 1'b1;
        head_r            <= head_nxt;
      end
      if (v1_r) begin
        total_r <= total_nxt;
      end
      if (v3_r) begin
        if (last3) begin
          phase_r <= '0;
          ft_r    <= '0;
          min_r   <= '1;
          max_r   <= '0;
        end else begin
          phase_r <= phase_r + 1'b1;
          if (kept3) begin
            ft_r  <= ft_nxt;
            min_r <= min_nxt;
            max_r <= max_nxt;
          end
        end
      end
    end
  end

  // payload registers along the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      samp1_r  <= in_sample_mv;
      tot2_r   <= total_nxt;
      filt3_r  <= win_prod[mafs_pkg::WIN_K +: mafs_pkg::SAMPLE_W];
      filt4_r  <= filt3_r;
      kept4_r  <= kept3;
      last4_r  <= last3;
      idx4_r   <= idx3;
      min4_r   <= min_nxt;
      max4_r   <= max_nxt;
      ft4_r    <= ft_nxt;
      o_filt_r <= filt4_r;
      o_kept_r <= kept4_r;
      o_idx_r  <= idx4_r;
      o_last_r <= last4_r;
      o_min_r  <= last4_r ? min4_r : '0;
      o_max_r  <= last4_r ? max4_r : '0;
      o_mean_r <= last4_r ? ft_prod[mafs_pkg::FT_K +: mafs_pkg::SAMPLE_W] : '0;
      o_span_r <= last4_r ? (max4_r - min4_r) : '0;
    end
  end

  // result beat
  assign out_valid       = out_valid_r;
  assign out_filtered    = o_filt_r;
  assign out_in_frame    = o_kept_r;
  assign out_frame_index = o_idx_r;
  assign out_frame_end   = o_last_r;
  assign out_frame_min   = o_min_r;
  assign out_frame_max   = o_max_r;
  assign out_frame_mean  = o_mean_r;
  assign out_frame_span  = o_span_r;

  // checks
  `MAFS_ASSERT_NOW(a_end_pos, out_valid_r && o_last_r, o_kept_r && (o_idx_r == mafs_pkg::INDEX_W'(mafs_pkg::FRAME_LEN - 1)), "frame end beat at wrong position")
  `MAFS_ASSERT_NOW(a_end_order, out_valid_r && o_last_r, (o_min_r <= o_max_r) && (o_span_r == o_max_r - o_min_r), "frame end statistics inconsistent")
  `MAFS_ASSERT_NOW(a_phase_rng, 1'b1, phase_r <= mafs_pkg::PH_W'(mafs_pkg::PH_LAST), "frame phase counter out of range")
  `MAFS_ASSERT_NEXT(a_head_step, acc, head_r == $past(head_nxt), "window head did not advance on accept")

endmodule

`default_nettype wire
